/* rtl/core/pfn_pkg.sv */
// Shared widths and pipeline side-band type for the face normal unit.
package pfn_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW  = 17;
  localparam int unsigned ProdW  = 34;
  localparam int unsigned MagW   = 34;
  localparam int unsigned NrmW   = 30;
  localparam int unsigned SqW    = 60;
  localparam int unsigned SumW   = 62;
  localparam int unsigned RootW  = 31;
  localparam int unsigned QuoW   = 15;
  localparam int unsigned NormPos = 29;
  localparam logic [QuoW-1:0] QOne = 15'd16384;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [2:0][NrmW-1:0]  mag;
  } pfn_side_t;

endpackage

/* rtl/core/polygon_face_normal_unit.sv */
// Face normal unit: pipelined cross product and normalization to a Q1.14 unit vector.
//
// Usage: present the first, second and last vertex of a face (signed Q8.8) and
// raise start_i; the face is taken at each rising edge where start_i is high and
// busy_o is low. busy_o is always low: a new face may enter every cycle.
// Each result appears on normal_*_o and degenerate_o for exactly one cycle,
// marked by done_o, in the order faces were taken.
// A face passes, in order, through 7 stages of edge, product, cross,
// leading-one search, shift, square and sum, 1 square-root input stage,
// 31 square-root stages (one root bit each), 1 dividend setup stage,
// 15 division stages (one quotient bit each) and the output register.
// Throughput is one face per cycle; the pipeline never stalls since the
// receiver cannot hold results off.
// A face whose cross product is zero gives degenerate_o = 1 and a zero normal.
// Reset clears all valid bits; data registers are not reset, and no result is
// shown until a face taken after reset reaches the end.
module polygon_face_normal_unit import pfn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [CoordW-1:0] first_x_i,
  input  logic signed [CoordW-1:0] first_y_i,
  input  logic signed [CoordW-1:0] first_z_i,
  input  logic signed [CoordW-1:0] second_x_i,
  input  logic signed [CoordW-1:0] second_y_i,
  input  logic signed [CoordW-1:0] second_z_i,
  input  logic signed [CoordW-1:0] last_x_i,
  input  logic signed [CoordW-1:0] last_y_i,
  input  logic signed [CoordW-1:0] last_z_i,
  output logic                     done_o,
  output logic signed [CoordW-1:0] normal_x_o,
  output logic signed [CoordW-1:0] normal_y_o,
  output logic signed [CoordW-1:0] normal_z_o,
  output logic                     degenerate_o
);

  logic                      v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic signed [EdgeW-1:0]   e1_q [3];
  logic signed [EdgeW-1:0]   e2_q [3];
  logic signed [ProdW-1:0]   p_q  [6];
  logic [2:0][MagW-1:0]      mag3_q, mag4_q;
  logic [2:0]                neg3_q, neg4_q, neg5_q, neg6_q, neg7_q;
  logic [5:0]                pos4_q;
  logic                      degen4_q, degen5_q, degen6_q, degen7_q;
  logic [2:0][NrmW-1:0]      nrm5_q, nrm6_q, nrm7_q;
  logic [2:0][SqW-1:0]       sq6_q;
  logic [SumW-1:0]           sum7_q;
  logic [MagW-1:0]           big;
  logic [5:0]                pos_d;
  pfn_side_t                 side7;
  logic                      sq_valid;
  logic [RootW-1:0]          root;
  pfn_side_t                 sq_side;
  logic [2:0][CoordW-1:0]    normal;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= start_i & ~busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // Edge vectors from the first vertex.
  always_ff @(posedge clk_i) begin
    e1_q[0] <= EdgeW'(second_x_i) - EdgeW'(first_x_i);
    e1_q[1] <= EdgeW'(second_y_i) - EdgeW'(first_y_i);
    e1_q[2] <= EdgeW'(second_z_i) - EdgeW'(first_z_i);
    e2_q[0] <= EdgeW'(last_x_i) - EdgeW'(first_x_i);
    e2_q[1] <= EdgeW'(last_y_i) - EdgeW'(first_y_i);
    e2_q[2] <= EdgeW'(last_z_i) - EdgeW'(first_z_i);
  end

  always_ff @(posedge clk_i) begin
    p_q[0] <= ProdW'(e1_q[1] * e2_q[2]);
    p_q[1] <= ProdW'(e1_q[2] * e2_q[1]);
    p_q[2] <= ProdW'(e1_q[2] * e2_q[0]);
    p_q[3] <= ProdW'(e1_q[0] * e2_q[2]);
    p_q[4] <= ProdW'(e1_q[0] * e2_q[1]);
    p_q[5] <= ProdW'(e1_q[1] * e2_q[0]);
  end

  // Cross product components as sign and magnitude.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic signed [ProdW:0] n;
      n = (ProdW+1)'(p_q[2*i]) - (ProdW+1)'(p_q[2*i+1]);
      neg3_q[i] <= n[ProdW];
      mag3_q[i] <= n[ProdW] ? MagW'(-n) : MagW'(n);
    end
  end

  always_comb begin
    big = mag3_q[0];
    if (mag3_q[1] > big) big = mag3_q[1];
    if (mag3_q[2] > big) big = mag3_q[2];
  end

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (big[i]) pos_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    mag4_q   <= mag3_q;
    neg4_q   <= neg3_q;
    pos4_q   <= pos_d;
    degen4_q <= (big == '0);
  end

  // Bring the largest magnitude into [2^29, 2^30).
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (pos4_q > 6'(NormPos)) begin
        nrm5_q[i] <= NrmW'(mag4_q[i] >> (pos4_q - 6'(NormPos)));
      end else begin
        nrm5_q[i] <= NrmW'(mag4_q[i] << (6'(NormPos) - pos4_q));
      end
    end
    neg5_q   <= neg4_q;
    degen5_q <= degen4_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sq6_q[i] <= SqW'(nrm5_q[i] * nrm5_q[i]);
    end
    nrm6_q   <= nrm5_q;
    neg6_q   <= neg5_q;
    degen6_q <= degen5_q;
  end

  always_ff @(posedge clk_i) begin
    sum7_q   <= SumW'(sq6_q[0]) + SumW'(sq6_q[1]) + SumW'(sq6_q[2]);
    nrm7_q   <= nrm6_q;
    neg7_q   <= neg6_q;
    degen7_q <= degen6_q;
  end

  assign side7.neg   = neg7_q;
  assign side7.degen = degen7_q;
  assign side7.mag   = nrm7_q;

  pfn_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .sum_i   (sum7_q),
    .side_i  (side7),
    .valid_o (sq_valid),
    .root_o  (root),
    .side_o  (sq_side)
  );

  pfn_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_valid),
    .len_i    (root),
    .side_i   (sq_side),
    .valid_o  (done_o),
    .normal_o (normal),
    .degen_o  (degenerate_o)
  );

  assign normal_x_o = normal[0];
  assign normal_y_o = normal[1];
  assign normal_z_o = normal[2];

endmodule

/* rtl/core/pfn_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module pfn_sqrt import pfn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [SumW-1:0]  sum_i,
  input  pfn_side_t        side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output pfn_side_t        side_o
);

  logic [RootW:0]    valid_q;
  logic [SumW-1:0]   rem_q  [RootW+1];
  logic [RootW-1:0]  root_q [RootW+1];
  pfn_side_t         side_q [RootW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= sum_i;
    root_q[0] <= '0;
    side_q[0] <= side_i;
  end

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int unsigned K = RootW - 1 - j;
    logic [SumW:0]    trial;
    logic [SumW:0]    rem_ext;
    logic             take;
    logic [SumW-1:0]  rem_d;
    logic [RootW-1:0] root_d;

    assign trial   = ((SumW+1)'(root_q[j]) << (K + 1)) + ((SumW+1)'(1) << (2 * K));
    assign rem_ext = {1'b0, rem_q[j]};
    assign take    = rem_ext >= trial;
    assign rem_d   = take ? SumW'(rem_ext - trial) : rem_q[j];
    assign root_d  = take ? (root_q[j] | (RootW'(1) << K)) : root_q[j];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else begin
        valid_q[j+1] <= valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]  <= rem_d;
      root_q[j+1] <= root_d;
      side_q[j+1] <= side_q[j];
    end
  end

  assign valid_o = valid_q[RootW];
  assign root_o  = root_q[RootW];
  assign side_o  = side_q[RootW];

endmodule

/* rtl/core/pfn_div.sv */
// Pipelined restoring division of the three magnitudes by the length, plus output register.
module pfn_div import pfn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RootW-1:0]  len_i,
  input  pfn_side_t         side_i,
  output logic              valid_o,
  output logic [2:0][CoordW-1:0] normal_o,
  output logic              degen_o
);

  localparam int unsigned NumW = NrmW + QuoW + 1;
  localparam int unsigned DenW = RootW + 1;

  logic [QuoW:0]          valid_q;
  logic [2:0][NumW-1:0]   rem_q  [QuoW+1];
  logic [2:0][QuoW-1:0]   quo_q  [QuoW+1];
  logic [DenW-1:0]        den_q  [QuoW+1];
  logic [2:0]             neg_q  [QuoW+1];
  logic                   degen_q[QuoW+1];
  logic                   out_valid_q;
  logic [2:0][CoordW-1:0] out_q;
  logic                   out_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0]  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q[0]  <= valid_i;
      out_valid_q <= valid_q[QuoW];
    end
  end

  // Round half up: (a * 2^15 + L) / (2 * L).
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      rem_q[0][i] <= {1'b0, side_i.mag[i], {QuoW{1'b0}}} + NumW'(len_i);
    end
    quo_q[0]   <= '0;
    den_q[0]   <= {len_i, 1'b0};
    neg_q[0]   <= side_i.neg;
    degen_q[0] <= side_i.degen;
  end

  for (genvar j = 0; j < QuoW; j++) begin : g_stage
    localparam int unsigned K = QuoW - 1 - j;
    logic [NumW:0]          dsh;
    logic [2:0][NumW-1:0]   rem_d;
    logic [2:0][QuoW-1:0]   quo_d;

    assign dsh = (NumW+1)'(den_q[j]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem_q[j][i]} >= dsh) begin
          rem_d[i] = NumW'({1'b0, rem_q[j][i]} - dsh);
          quo_d[i] = quo_q[j][i] | (QuoW'(1) << K);
        end else begin
          rem_d[i] = rem_q[j][i];
          quo_d[i] = quo_q[j][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else begin
        valid_q[j+1] <= valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1]   <= rem_d;
      quo_q[j+1]   <= quo_d;
      den_q[j+1]   <= den_q[j];
      neg_q[j+1]   <= neg_q[j];
      degen_q[j+1] <= degen_q[j];
    end
  end

  // Saturate, apply sign, zero out degenerate faces.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      logic [QuoW-1:0]   q;
      logic [CoordW-1:0] m;
      q = (quo_q[QuoW][i] > QOne) ? QOne : quo_q[QuoW][i];
      m = CoordW'(q);
      if (degen_q[QuoW]) begin
        out_q[i] <= '0;
      end else if (neg_q[QuoW][i]) begin
        out_q[i] <= CoordW'(-m);
      end else begin
        out_q[i] <= m;
      end
    end
    out_degen_q <= degen_q[QuoW];
  end

  assign valid_o  = out_valid_q;
  assign normal_o = out_q;
  assign degen_o  = out_degen_q;

endmodule

/* bench/polygon_face_normal_unit_tb.sv */
// Self-checking testbench for the face normal unit: cross product and Q1.14 normalization.
module polygon_face_normal_unit_tb import pfn_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  int unsigned err_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Holds expected normals in face order.
  class normal_scoreboard;
    normal_t pending_q[$];

    function automatic logic [63:0] root64(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic void note_face(input logic signed [15:0] v [9]);
      longint e1[3], e2[3], n[3];
      logic [63:0] a[3], big, sum, len, q;
      logic neg[3];
      normal_t r;
      logic signed [15:0] comp[3];
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(v[3+i]) - longint'(v[i]);
        e2[i] = longint'(v[6+i]) - longint'(v[i]);
      end
      n[0] = e1[1]*e2[2] - e1[2]*e2[1];
      n[1] = e1[2]*e2[0] - e1[0]*e2[2];
      n[2] = e1[0]*e2[1] - e1[1]*e2[0];
      for (int i = 0; i < 3; i++) begin
        neg[i] = n[i] < 0;
        a[i] = neg[i] ? -n[i] : n[i];
      end
      if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
        r.nx = 0; r.ny = 0; r.nz = 0; r.degen = 1'b1;
      end else begin
        big = a[0];
        if (a[1] > big) big = a[1];
        if (a[2] > big) big = a[2];
        while (big >= 64'h4000_0000) begin
          big = big >> 1;
          for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
        end
        while (big < 64'h2000_0000) begin
          big = big << 1;
          for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
        end
        sum = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
          q = ((a[i] << 15) + len) / (2 * len);
          if (q > QOne) q = QOne;   // saturate rounding above one
          comp[i] = neg[i] ? -16'(q) : 16'(q);
        end
        r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2]; r.degen = 1'b0;
      end
      pending_q = {pending_q, r};
    endfunction

    task automatic check_normal(input normal_t got);
      normal_t e;
      if (pending_q.size() == 0) begin
        report_mismatch("result with no face outstanding");
        return;
      end
      e = pending_q.pop_front();
      if (got.nx !== e.nx) report_mismatch($sformatf("normal_x %0d exp %0d", got.nx, e.nx));
      if (got.ny !== e.ny) report_mismatch($sformatf("normal_y %0d exp %0d", got.ny, e.ny));
      if (got.nz !== e.nz) report_mismatch($sformatf("normal_z %0d exp %0d", got.nz, e.nz));
      if (got.degen !== e.degen)
        report_mismatch($sformatf("degenerate %0b exp %0b", got.degen, e.degen));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o, degenerate_o;
  logic signed [15:0] vert [9];
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;

  normal_scoreboard board = new();
  int unsigned idle_pct = 0;

  always #5 clk_i = ~clk_i;

  initial for (int i = 0; i < 9; i++) vert[i] = '0;

  polygon_face_normal_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .first_x_i(vert[0]), .first_y_i(vert[1]), .first_z_i(vert[2]),
    .second_x_i(vert[3]), .second_y_i(vert[4]), .second_z_i(vert[5]),
    .last_x_i(vert[6]), .last_y_i(vert[7]), .last_z_i(vert[8]),
    .done_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  // Sample results and transfers on each rising edge.
  always @(posedge clk_i) begin
    normal_t got;
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_face(vert);
      if (done_o) begin
        got.nx = normal_x_o; got.ny = normal_y_o; got.nz = normal_z_o;
        got.degen = degenerate_o;
        board.check_normal(got);
      end
    end
  end

  // Present one face, hold start until it transfers.
  task automatic send_face(input logic signed [15:0] f [9]);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    for (int i = 0; i < 9; i++) vert[i] <= f[i];
    start_i <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    logic signed [15:0] f [9];
    int kind;
    for (int k = 0; k < count; k++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 9; i++) f[i] = rand_coord();
      if (kind == 0) begin
        for (int i = 0; i < 3; i++) f[3+i] = f[i];   // coincident vertices
      end else if (kind == 1) begin
        // collinear: last = first + 2 * (second - first) where it fits
        for (int i = 0; i < 3; i++) begin
          f[i] = 16'($urandom_range(4000)) - 16'sd2000;
          f[3+i] = f[i] + 16'($urandom_range(4000)) - 16'sd2000;
          f[6+i] = f[i] + 16'sd2 * (f[3+i] - f[i]);
        end
      end
      send_face(f);
    end
  endtask

  task automatic send_directed();
    logic signed [15:0] f [9];
    logic signed [15:0] pat [6][9] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 256, 0, 0, 0, 256, 0},
      '{0, 0, 0, 0, 256, 0, 256, 0, 0},
      '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh7fff, 16'sh8000},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh7fff},
      '{1, 1, 1, 2, 2, 2, 3, 3, 3}
    };
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 9; i++) f[i] = pat[p][i];
      send_face(f);
    end
    // tiny and diagonal faces exercise the shift and rounding paths
    f = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_face(f);
    f = '{0, 0, 0, 1, 1, 0, 0, 1, 1}; send_face(f);
    f = '{0, 0, 0, -1, 2, 3, 5, -7, 11}; send_face(f);
    f = '{-5, 9, 3, -5, 9, 3, 100, 200, 300}; send_face(f);
    f = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}; send_face(f);
    f = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_face(f);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    idle_pct = 0;  send_random(300);
    idle_pct = 73; send_random(300);
    idle_pct = 19; send_random(250);
    idle_pct = 0;  send_random(300);
    start_i <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pfn_pkg.sv
rtl/core/pfn_sqrt.sv
rtl/core/pfn_div.sv
rtl/core/polygon_face_normal_unit.sv
bench/polygon_face_normal_unit_tb.sv
